@@ hw/rtl/assert_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion wrappers, compiled out for synthesis.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// Property checked at every rising clock edge outside reset.
`define ASSERT_AT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Condition that must never be true outside reset.
`define ASSERT_NEVER(lbl, clk, rst_n, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);
`else
`define ASSERT_AT(lbl, clk, rst_n, prop, msg)
`define ASSERT_NEVER(lbl, clk, rst_n, expr, msg)
`endif

`endif

@@ hw/rtl/md5de_pkg.sv @@
// ----------------------------------------------------------------------------
// MD5 digest engine package
// Transaction types, control states and round tables.
// ----------------------------------------------------------------------------
package md5de_pkg;

  typedef struct packed {
    logic [31:0] message_word;
    logic [2:0]  byte_count;
    logic        final_item;
  } md5de_in_t;

  typedef struct packed {
    logic [31:0] digest_word;
    logic [1:0]  word_number;
    logic        digest_done;
  } md5de_out_t;

  typedef struct packed {
    logic [31:0] a;
    logic [31:0] b;
    logic [31:0] c;
    logic [31:0] d;
  } md5de_abcd_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_PAD,
    ST_COMP,
    ST_FINISH
  } md5de_state_e;

  localparam logic [31:0] INIT_A   = 32'h67452301;
  localparam logic [31:0] INIT_B   = 32'hefcdab89;
  localparam logic [31:0] INIT_C   = 32'h98badcfe;
  localparam logic [31:0] INIT_D   = 32'h10325476;
  localparam logic [31:0] PAD_WORD = 32'h00000080;

  localparam logic [2:0] FULL_COUNT = 3'd4;
  localparam logic [6:0] RND_LAST   = 7'd64;
  localparam logic [6:0] RND_ADD    = 7'd65;

  function automatic logic [3:0] msg_index(input logic [5:0] r);
    logic [3:0] i;
    logic [3:0] idx;
    i = r[3:0];
    case (r[5:4])
      2'd0:    idx = i;
      2'd1:    idx = 4'(i * 4'd5 + 4'd1);
      2'd2:    idx = 4'(i * 4'd3 + 4'd5);
      default: idx = 4'(i * 4'd7);
    endcase
    return idx;
  endfunction

  function automatic logic [4:0] rot_amount(input logic [5:0] r);
    logic [4:0] s;
    case ({r[5:4], r[1:0]})
      4'h0: s = 5'd7;
      4'h1: s = 5'd12;
      4'h2: s = 5'd17;
      4'h3: s = 5'd22;
      4'h4: s = 5'd5;
      4'h5: s = 5'd9;
      4'h6: s = 5'd14;
      4'h7: s = 5'd20;
      4'h8: s = 5'd4;
      4'h9: s = 5'd11;
      4'ha: s = 5'd16;
      4'hb: s = 5'd23;
      4'hc: s = 5'd6;
      4'hd: s = 5'd10;
      4'he: s = 5'd15;
      default: s = 5'd21;
    endcase
    return s;
  endfunction

  function automatic logic [31:0] round_const(input logic [5:0] r);
    logic [31:0] k;
    case (r)
      6'd0:  k = 32'hd76aa478;  6'd1:  k = 32'he8c7b756;
      6'd2:  k = 32'h242070db;  6'd3:  k = 32'hc1bdceee;
      6'd4:  k = 32'hf57c0faf;  6'd5:  k = 32'h4787c62a;
      6'd6:  k = 32'ha8304613;  6'd7:  k = 32'hfd469501;
      6'd8:  k = 32'h698098d8;  6'd9:  k = 32'h8b44f7af;
      6'd10: k = 32'hffff5bb1;  6'd11: k = 32'h895cd7be;
      6'd12: k = 32'h6b901122;  6'd13: k = 32'hfd987193;
      6'd14: k = 32'ha679438e;  6'd15: k = 32'h49b40821;
      6'd16: k = 32'hf61e2562;  6'd17: k = 32'hc040b340;
      6'd18: k = 32'h265e5a51;  6'd19: k = 32'he9b6c7aa;
      6'd20: k = 32'hd62f105d;  6'd21: k = 32'h02441453;
      6'd22: k = 32'hd8a1e681;  6'd23: k = 32'he7d3fbc8;
      6'd24: k = 32'h21e1cde6;  6'd25: k = 32'hc33707d6;
      6'd26: k = 32'hf4d50d87;  6'd27: k = 32'h455a14ed;
      6'd28: k = 32'ha9e3e905;  6'd29: k = 32'hfcefa3f8;
      6'd30: k = 32'h676f02d9;  6'd31: k = 32'h8d2a4c8a;
      6'd32: k = 32'hfffa3942;  6'd33: k = 32'h8771f681;
      6'd34: k = 32'h6d9d6122;  6'd35: k = 32'hfde5380c;
      6'd36: k = 32'ha4beea44;  6'd37: k = 32'h4bdecfa9;
      6'd38: k = 32'hf6bb4b60;  6'd39: k = 32'hbebfbc70;
      6'd40: k = 32'h289b7ec6;  6'd41: k = 32'heaa127fa;
      6'd42: k = 32'hd4ef3085;  6'd43: k = 32'h04881d05;
      6'd44: k = 32'hd9d4d039;  6'd45: k = 32'he6db99e5;
      6'd46: k = 32'h1fa27cf8;  6'd47: k = 32'hc4ac5665;
      6'd48: k = 32'hf4292244;  6'd49: k = 32'h432aff97;
      6'd50: k = 32'hab9423a7;  6'd51: k = 32'hfc93a039;
      6'd52: k = 32'h655b59c3;  6'd53: k = 32'h8f0ccc92;
      6'd54: k = 32'hffeff47d;  6'd55: k = 32'h85845dd1;
      6'd56: k = 32'h6fa87e4f;  6'd57: k = 32'hfe2ce6e0;
      6'd58: k = 32'ha3014314;  6'd59: k = 32'h4e0811a1;
      6'd60: k = 32'hf7537e82;  6'd61: k = 32'hbd3af235;
      6'd62: k = 32'h2ad7d2bb;  default: k = 32'heb86d391;
    endcase
    return k;
  endfunction

endpackage

@@ hw/rtl/md5de_round.sv @@
// ----------------------------------------------------------------------------
// MD5 round datapath
// One MD5 round: boolean function, four-way add, rotate and state shift.
// ----------------------------------------------------------------------------
module md5de_round
  import md5de_pkg::*;
(
  input  md5de_abcd_t state_i,
  input  logic [31:0] msg_i,
  input  logic [5:0]  rnd_i,
  output md5de_abcd_t state_o
);

  logic [31:0] f;
  logic [31:0] t;
  logic [63:0] rot_wide;

  always_comb begin
    case (rnd_i[5:4])
      2'd0:    f = (state_i.b & state_i.c) | (~state_i.b & state_i.d);
      2'd1:    f = (state_i.d & state_i.b) | (~state_i.d & state_i.c);
      2'd2:    f = state_i.b ^ state_i.c ^ state_i.d;
      default: f = state_i.c ^ (state_i.b | ~state_i.d);
    endcase
  end

  assign t        = f + state_i.a + round_const(rnd_i) + msg_i;
  assign rot_wide = {t, t} << rot_amount(rnd_i);

  assign state_o.a = state_i.d;
  assign state_o.d = state_i.c;
  assign state_o.c = state_i.b;
  assign state_o.b = state_i.b + rot_wide[63:32];

endmodule

@@ hw/rtl/md5_digest_engine_unit.sv @@
// ----------------------------------------------------------------------------
// MD5 digest engine
// Gathers 32-bit words into a 16-word block memory, compresses each full
// block and emits the four-word digest after padding on the last word.
// ----------------------------------------------------------------------------
// Each accepted word is written into the block memory; a full block then goes
// through compression (one round per cycle on the single read port).
// Input is accepted only while idle, not during padding, compression or the
// digest load. A last word adds padding words and one or two compressions,
// then 4 digest transactions drain from a buffer while the next message loads.
// Reset: asynchronous; chaining value to MD5 initial values, counts to zero.
module md5_digest_engine_unit
  import md5de_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  md5de_in_t  in_data_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output md5de_out_t out_data_o
);

  `include "assert_macros.svh"

  md5de_state_e state_q, state_d;

  logic [3:0]  fill_q;
  logic [63:0] len_q;
  logic        final_pend_q;
  logic        need80_q;
  logic        blocked_q;
  logic        len_done_q;
  logic [6:0]  rnd_q;
  md5de_abcd_t cv_q;
  md5de_abcd_t work_q;
  md5de_abcd_t round_out;

  logic [31:0] mem_q [16];
  logic [31:0] rdata_q;
  logic [3:0]  rd_addr;

  logic [31:0] obuf_q [4];
  logic        obusy_q;
  logic [1:0]  oidx_q;

  logic        in_fire;
  logic        out_fire;
  logic        short_last;
  logic [2:0]  cnt_eff;
  logic [31:0] keep_mask;
  logic [31:0] acc_word;
  logic [31:0] pad_word;
  logic        wr_en;
  logic [31:0] wr_data;
  logic        load_out;

  assign in_ready_o  = (state_q == ST_IDLE);
  assign in_fire     = in_valid_i && in_ready_o;
  assign out_valid_o = obusy_q;
  assign out_fire    = out_valid_o && out_ready_i;
  assign load_out    = (state_q == ST_FINISH) && !obusy_q;

  assign out_data_o.digest_word = obuf_q[oidx_q];
  assign out_data_o.word_number = oidx_q;
  assign out_data_o.digest_done = (oidx_q == 2'd3);

  // Build the word to store: message word, padded short word or padding.
  always_comb begin
    short_last = in_data_i.final_item && (in_data_i.byte_count < FULL_COUNT);
    cnt_eff    = short_last ? in_data_i.byte_count : FULL_COUNT;
    case (in_data_i.byte_count[1:0])
      2'd0:    keep_mask = 32'h00000000;
      2'd1:    keep_mask = 32'h000000ff;
      2'd2:    keep_mask = 32'h0000ffff;
      default: keep_mask = 32'h00ffffff;
    endcase
    if (short_last) begin
      acc_word = (in_data_i.message_word & keep_mask) |
                 (PAD_WORD << {in_data_i.byte_count[1:0], 3'b000});
    end else begin
      acc_word = in_data_i.message_word;
    end
    if (need80_q) begin
      pad_word = PAD_WORD;
    end else if (!blocked_q && fill_q == 4'd14) begin
      pad_word = len_q[31:0];
    end else if (!blocked_q && fill_q == 4'd15) begin
      pad_word = len_q[63:32];
    end else begin
      pad_word = '0;
    end
  end

  always_comb begin
    wr_en   = in_fire || (state_q == ST_PAD);
    wr_data = (state_q == ST_PAD) ? pad_word : acc_word;
    rd_addr = msg_index(rnd_q[5:0]);
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          if (fill_q == 4'd15) begin
            state_d = ST_COMP;
          end else if (in_data_i.final_item) begin
            state_d = ST_PAD;
          end
        end
      end
      ST_PAD: begin
        if (fill_q == 4'd15) begin
          state_d = ST_COMP;
        end
      end
      ST_COMP: begin
        if (rnd_q == RND_ADD) begin
          if (len_done_q) begin
            state_d = ST_FINISH;
          end else if (final_pend_q) begin
            state_d = ST_PAD;
          end else begin
            state_d = ST_IDLE;
          end
        end
      end
      ST_FINISH: begin
        if (!obusy_q) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  md5de_round u_round (
    .state_i (work_q),
    .msg_i   (rdata_q),
    .rnd_i   (6'(rnd_q - 7'd1)),
    .state_o (round_out)
  );

  // Block memory: one write port, one registered read port.
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[fill_q] <= wr_data;
    end
    rdata_q <= mem_q[rd_addr];
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_COMP) begin
      if (rnd_q == '0) begin
        work_q <= cv_q;
      end else if (rnd_q <= RND_LAST) begin
        work_q <= round_out;
      end
    end
    if (load_out) begin
      obuf_q[0] <= cv_q.a;
      obuf_q[1] <= cv_q.b;
      obuf_q[2] <= cv_q.c;
      obuf_q[3] <= cv_q.d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      fill_q       <= '0;
      len_q        <= '0;
      final_pend_q <= 1'b0;
      need80_q     <= 1'b0;
      blocked_q    <= 1'b0;
      len_done_q   <= 1'b0;
      rnd_q        <= '0;
      cv_q         <= '{a: INIT_A, b: INIT_B, c: INIT_C, d: INIT_D};
      obusy_q      <= 1'b0;
      oidx_q       <= '0;
    end else begin
      state_q <= state_d;
      if (wr_en) begin
        fill_q <= fill_q + 4'd1;
      end
      if (in_fire) begin
        len_q        <= len_q + 64'({cnt_eff, 3'b000});
        final_pend_q <= in_data_i.final_item;
        need80_q     <= in_data_i.final_item && !short_last;
        blocked_q    <= short_last && (fill_q >= 4'd14);
      end
      if (state_q == ST_PAD) begin
        if (need80_q) begin
          need80_q <= 1'b0;
          if (fill_q >= 4'd14) begin
            blocked_q <= 1'b1;
          end
        end else if (!blocked_q && fill_q == 4'd15) begin
          len_done_q <= 1'b1;
        end
      end
      if (state_q == ST_COMP) begin
        if (rnd_q == RND_ADD) begin
          rnd_q     <= '0;
          blocked_q <= 1'b0;
          cv_q.a    <= cv_q.a + work_q.a;
          cv_q.b    <= cv_q.b + work_q.b;
          cv_q.c    <= cv_q.c + work_q.c;
          cv_q.d    <= cv_q.d + work_q.d;
        end else begin
          rnd_q <= rnd_q + 7'd1;
        end
      end
      if (load_out) begin
        obusy_q      <= 1'b1;
        oidx_q       <= '0;
        cv_q         <= '{a: INIT_A, b: INIT_B, c: INIT_C, d: INIT_D};
        len_q        <= '0;
        final_pend_q <= 1'b0;
        need80_q     <= 1'b0;
        blocked_q    <= 1'b0;
        len_done_q   <= 1'b0;
      end
      if (out_fire) begin
        oidx_q <= oidx_q + 2'd1;
        if (oidx_q == 2'd3) begin
          obusy_q <= 1'b0;
        end
      end
    end
  end

  `ASSERT_AT(a_comp_fill, clk_i, rst_ni, state_q == ST_COMP |-> fill_q == '0,
             "block not full at compression")
  `ASSERT_AT(a_rnd_idle, clk_i, rst_ni, state_q != ST_COMP |-> rnd_q == '0,
             "round counter left running")
  `ASSERT_AT(a_hold_digest, clk_i, rst_ni,
             state_q == ST_FINISH && obusy_q |=> state_q == ST_FINISH,
             "digest overwrote output buffer")
  `ASSERT_NEVER(a_len_orphan, clk_i, rst_ni, len_done_q && (!final_pend_q || need80_q),
                "length written before padding byte")

endmodule

@@ tb/md5_digest_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// MD5 digest checker
// Watches both channels of the digest engine. Every accepted input
// transaction is folded into a local MD5 state; a last word closes the
// message and queues the four expected digest words, which are compared
// field by field against the output transactions in order.
// ----------------------------------------------------------------------------
module md5_digest_checker
  import md5de_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  input  logic       in_ready_i,
  input  md5de_in_t  in_data_i,
  input  logic       out_valid_i,
  input  logic       out_ready_i,
  input  md5de_out_t out_data_i,
  output int         pending_o,
  output int         errors_o
);

  localparam int PrintCap = 100;

  localparam logic [31:0] CHAIN_INIT [4] = '{
    32'h67452301, 32'hefcdab89, 32'h98badcfe, 32'h10325476
  };

  localparam int SHIFT_TABLE [16] = '{
    7, 12, 17, 22, 5, 9, 14, 20, 4, 11, 16, 23, 6, 10, 15, 21
  };

  localparam logic [31:0] SINE_K [64] = '{
    32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
    32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
    32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
    32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
    32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
    32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
    32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
    32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
    32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
    32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
    32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
    32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
    32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
    32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
    32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
    32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
  };

  localparam logic [31:0] PAD_BYTE = 32'h00000080;

  logic [31:0] chain [4];
  logic [31:0] blk [16];
  int unsigned fill;
  logic [63:0] bit_len;
  md5de_out_t  digest_q [$];
  md5de_out_t  want;

  initial errors_o = 0;

  task automatic report_fault(input string what);
    errors_o++;
    if (errors_o <= PrintCap) $display("digest check: %s", what);
  endtask

  function automatic void start_message();
    for (int k = 0; k < 4; k++) chain[k] = CHAIN_INIT[k];
    fill = 0;
    bit_len = '0;
  endfunction

  function automatic void compress_block();
    logic [31:0] a, b, c, d, f, t;
    int g;
    int s;
    a = chain[0];
    b = chain[1];
    c = chain[2];
    d = chain[3];
    for (int r = 0; r < 64; r++) begin
      case (r / 16)
        0: begin
          f = (b & c) | (~b & d);
          g = r;
        end
        1: begin
          f = (d & b) | (~d & c);
          g = (5 * r + 1) % 16;
        end
        2: begin
          f = b ^ c ^ d;
          g = (3 * r + 5) % 16;
        end
        default: begin
          f = c ^ (b | ~d);
          g = (7 * r) % 16;
        end
      endcase
      s = SHIFT_TABLE[(r / 16) * 4 + r % 4];
      t = f + a + SINE_K[r] + blk[g];
      a = d;
      d = c;
      c = b;
      b = b + ((t << s) | (t >> (32 - s)));
    end
    chain[0] += a;
    chain[1] += b;
    chain[2] += c;
    chain[3] += d;
  endfunction

  function automatic void push_word(input logic [31:0] w);
    blk[fill] = w;
    fill++;
    if (fill == 16) begin
      compress_block();
      fill = 0;
    end
  endfunction

  function automatic void absorb_word(input md5de_in_t item);
    int unsigned n;
    logic [31:0] mask;
    logic [31:0] tail;
    md5de_out_t  res;
    n = item.byte_count;
    if (!item.final_item || n > 4) n = 4;
    bit_len += 64'(n * 8);
    if (!item.final_item) begin
      push_word(item.message_word);
      return;
    end
    if (n == 4) begin
      push_word(item.message_word);
      push_word(PAD_BYTE);
    end else begin
      mask = (n == 0) ? 32'h0 : (32'hffffffff >> (32 - 8 * n));
      tail = PAD_BYTE << (8 * n);
      push_word((item.message_word & mask) | tail);
    end
    // no room for the length: close this block and open another
    if (fill > 14) begin
      while (fill != 0) push_word(32'h0);
    end
    while (fill < 14) push_word(32'h0);
    push_word(bit_len[31:0]);
    push_word(bit_len[63:32]);
    for (int k = 0; k < 4; k++) begin
      res.digest_word = chain[k];
      res.word_number = 2'(k);
      res.digest_done = (k == 3);
      digest_q.push_back(res);
    end
    start_message();
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_message();
      digest_q.delete();
      pending_o = 0;
    end else begin
      if (out_valid_i && out_ready_i) begin
        if (digest_q.size() == 0) begin
          report_fault($sformatf("unexpected digest word %h number %0d done %b",
                                 out_data_i.digest_word, out_data_i.word_number,
                                 out_data_i.digest_done));
        end else begin
          want = digest_q.pop_front();
          if (out_data_i.digest_word !== want.digest_word ||
              out_data_i.word_number !== want.word_number ||
              out_data_i.digest_done !== want.digest_done) begin
            report_fault($sformatf("digest got %h/%0d/%b expected %h/%0d/%b",
                                   out_data_i.digest_word, out_data_i.word_number,
                                   out_data_i.digest_done, want.digest_word,
                                   want.word_number, want.digest_done));
          end
        end
      end
      if (in_valid_i && in_ready_i) absorb_word(in_data_i);
      pending_o = digest_q.size();
    end
  end

endmodule

@@ tb/md5_digest_engine_unit_test.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// MD5 digest engine testbench
// Feeds directed and random messages word by word with random gaps and
// output stalls, then reports the verdict from the digest checker.
// ----------------------------------------------------------------------------
module md5_digest_engine_unit_test;
  import md5de_pkg::*;

  localparam int CycleLimit  = 300000;
  localparam int DrainCycles = 200;
  localparam int ItemTarget  = 180;

  logic       clk_i       = 1'b0;
  logic       rst_ni      = 1'b0;
  logic       in_valid_i  = 1'b0;
  md5de_in_t  in_data_i   = '0;
  logic       out_ready_i = 1'b0;
  logic       in_ready_o;
  logic       out_valid_o;
  md5de_out_t out_data_o;

  int   pending;
  int   errors;
  int   cycles = 0;
  int   sent = 0;
  logic calm = 1'b0;

  md5_digest_engine_unit dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o)
  );

  md5_digest_checker u_checker (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_i (in_ready_o),
    .in_data_i  (in_data_i),
    .out_valid_i(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_i (out_data_o),
    .pending_o  (pending),
    .errors_o   (errors)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= CycleLimit) begin
      $display("md5_digest_engine_unit_test: errors");
      $finish;
    end
  end

  // stall the digest side per transaction
  always begin : digest_sink
    int stall;
    @(negedge clk_i);
    stall = calm ? 0 : $urandom_range(0, 16);
    if (stall != 0) begin
      out_ready_i <= 1'b0;
      repeat (stall) @(negedge clk_i);
    end
    out_ready_i <= 1'b1;
    do @(posedge clk_i); while (!out_valid_o);
  end

  task automatic send_word(input logic [31:0] word, input logic [2:0] count,
                           input logic last);
    int gap;
    md5de_in_t item;
    @(negedge clk_i);
    gap = calm ? 0 : $urandom_range(0, 16);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    item.message_word = word;
    item.byte_count   = count;
    item.final_item   = last;
    in_data_i  <= item;
    in_valid_i <= 1'b1;
    do @(posedge clk_i); while (!in_ready_o);
    sent++;
  endtask

  // drop valid and hold until every digest has drained
  task automatic hold_off();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (pending != 0) @(negedge clk_i);
  endtask

  function automatic logic [31:0] pick_word();
    case ($urandom_range(0, 7))
      0:       return 32'h0;
      1:       return 32'hffffffff;
      default: return $urandom;
    endcase
  endfunction

  task automatic send_message(input int words);
    logic [2:0] cnt;
    calm = ($urandom_range(0, 3) == 0);
    for (int i = 0; i < words; i++) begin
      cnt = ($urandom_range(0, 7) == 0) ? 3'($urandom_range(0, 7)) : 3'd4;
      send_word(pick_word(), cnt, 1'b0);
    end
    send_word(pick_word(), 3'($urandom_range(0, 7)), 1'b1);
  endtask

  initial begin : stimulus
    int len;
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // single-word messages over byte counts zero to five and seven, extremes of the word
    send_word(32'h12345678, 3'd0, 1'b1);
    send_word(32'hffffffff, 3'd1, 1'b1);
    send_word(32'h00000000, 3'd2, 1'b1);
    send_word(32'hffffffff, 3'd3, 1'b1);
    send_word(32'h64636261, 3'd4, 1'b1);
    send_word(32'hffffffff, 3'd7, 1'b1);
    send_word(32'ha5a5a5a5, 3'd5, 1'b1);
    hold_off();
    // short counts on words that are not last, then a message of full words
    send_word(32'hffffffff, 3'd0, 1'b0);
    send_word(32'h00000000, 3'd3, 1'b0);
    send_word(32'h5a5a5a5a, 3'd6, 1'b1);
    send_word(32'hffffffff, 3'd4, 1'b0);
    send_word(32'h00000000, 3'd4, 1'b0);
    send_word(32'hffffffff, 3'd4, 1'b1);

    // padding spills into a second block, for the first message only if its last word is full
    send_message(13);
    send_message(14);
    while (sent < ItemTarget) begin
      if ($urandom_range(0, 4) == 0) hold_off();
      if ($urandom_range(0, 2) == 0) len = 13 + $urandom_range(0, 3) + 16 * $urandom_range(0, 1);
      else len = $urandom_range(0, 20);
      send_message(len);
    end
    calm = 1'b0;
    hold_off();
    repeat (DrainCycles) @(negedge clk_i);

    if (errors == 0) begin
      $display("md5_digest_engine_unit_test: clean");
    end else begin
      $display("md5_digest_engine_unit_test: errors");
    end
    $finish;
  end

endmodule

@@ files.f @@
+incdir+hw/rtl
hw/rtl/md5de_pkg.sv
hw/rtl/md5de_round.sv
hw/rtl/md5_digest_engine_unit.sv
tb/md5_digest_checker.sv
tb/md5_digest_engine_unit_test.sv
